FILE: hw/rtl/emng_pkg.sv
// ----------------------------------------------------------------------------
// emng_pkg: shared types and constants of the element mesh normal generator
// Function codes, status codes, register map, face tables and the command and
// status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package emng_pkg;

  localparam int VERTICES  = 4096;
  localparam int VAW       = $clog2(VERTICES);
  localparam int GROUP_MAX = 8;
  localparam int ONE_Q14   = 16384;

  // function codes of an input beat
  typedef enum logic [2:0] {
    FN_WRITE = 3'd0,
    FN_INDEX = 3'd1,
    FN_END   = 3'd2,
    FN_READ  = 3'd3,
    FN_CLEAR = 3'd4
  } func_e;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SIZE  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_CCW  = 2'd0;
  localparam logic [1:0] REG_PVM  = 2'd1;
  localparam logic [1:0] REG_VCNT = 2'd2;

  typedef enum logic [1:0] {
    EL_POINT = 2'd0,
    EL_TET   = 2'd1,
    EL_HEX   = 2'd2
  } elem_e;

  typedef struct packed {
    logic        ccw;
    logic        pvm;
    logic [12:0] vcnt;
  } cfg_t;

  // datapath commands, one group per cycle
  typedef struct packed {
    logic       load_a;
    logic       load_b;
    logic       load_c;
    logic       load_acc;
    logic       diff;
    logic       half_d;
    logic       mul_en;
    logic [3:0] mul_sel;
    logic       acc_en;
    logic [3:0] acc_sel;
    logic       half_v;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic [1:0] div_sel;
    logic       n_point;
    logic       n_unit_x;
    logic       n_zero;
    logic       n_neg;
    logic       acc_clr;
    logic       emit;
    logic       emit_zero;
    logic [1:0] emit_status;
    logic       emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic over_d;
    logic over_v;
    logic len_zero;
  } dp_stat_t;

  localparam logic [2:0] TET_FACES [4][3] = '{
    '{3'd0, 3'd1, 3'd2}, '{3'd0, 3'd2, 3'd3}, '{3'd0, 3'd3, 3'd1}, '{3'd1, 3'd3, 3'd2}
  };
  localparam logic [2:0] HEX_FACES [6][4] = '{
    '{3'd0, 3'd1, 3'd2, 3'd3}, '{3'd0, 3'd4, 3'd5, 3'd1}, '{3'd1, 3'd5, 3'd6, 3'd2},
    '{3'd2, 3'd6, 3'd7, 3'd3}, '{3'd3, 3'd7, 3'd4, 3'd0}, '{3'd5, 3'd4, 3'd7, 3'd6}
  };

  // group slot of one corner of one face
  function automatic logic [2:0] face_slot(elem_e k, logic [2:0] f, logic [2:0] c);
    logic [2:0] s;
    s = 3'd0;
    case (k)
      EL_TET:  s = TET_FACES[f[1:0]][c[1:0]];
      EL_HEX:  s = HEX_FACES[f][c[1:0]];
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/element_mesh_normal_generator.sv
// ----------------------------------------------------------------------------
// element_mesh_normal_generator: face and vertex normals of mesh elements
// Input beats are taken at a rising edge with start high and busy low.
// Coordinate writes, index tokens and unused codes leave busy low. A
// group or read that fails its checks also leaves busy low, and its error
// result strobes in the next cycle. A point element takes the +z unit
// normal without arithmetic. Any other face goes through one shared
// multiplier, a 32-step square root and a 15-step divider per component,
// and a zero-area face skips the divider. Differences or products are
// halved when they are out of range. Per-vertex mode adds an accumulator
// read and write for each corner of each face, and of a point element.
// A normal read runs the accumulated sum through the square root and the
// divider, and skips the divider for a zero sum.
// Each result is a one-cycle strobe on valid_o, with last_o on the final one.
// The receiver cannot stall. After reset, and after a clear beat, the
// accumulator memory is zeroed one entry a cycle, all 4096 entries, with busy
// high. The register port stays usable throughout.
// Registers: 0x0 ccw (reset 1), 0x4 per_vertex_mode (reset 0),
// 0x8 vertex_count (reset 0).
// ----------------------------------------------------------------------------
module element_mesh_normal_generator
  import emng_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic [11:0] vertex_i,
  input  logic [31:0] coord_x_i,
  input  logic [31:0] coord_y_i,
  input  logic [31:0] coord_z_i,
  output logic        valid_o,
  output logic [15:0] normal_x_o,
  output logic [15:0] normal_y_o,
  output logic [15:0] normal_z_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  cfg_t           cfg_q;
  dp_cmd_t        cmd;
  dp_stat_t       stat;
  logic           coord_we, acc_we;
  logic [VAW-1:0] coord_addr, acc_addr;
  logic [95:0]    coord_rdata, acc_rdata, acc_wdata;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ccw  <= 1'b1;
      cfg_q.pvm  <= 1'b0;
      cfg_q.vcnt <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_CCW:  cfg_q.ccw  <= pwdata[0];
        REG_PVM:  cfg_q.pvm  <= pwdata[0];
        REG_VCNT: cfg_q.vcnt <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CCW:  prdata = {31'd0, cfg_q.ccw};
      REG_PVM:  prdata = {31'd0, cfg_q.pvm};
      REG_VCNT: prdata = {19'd0, cfg_q.vcnt};
      default:  prdata = '0;
    endcase
  end

  emng_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .vertex_i     (vertex_i),
    .cfg_i        (cfg_q),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .coord_we_o   (coord_we),
    .coord_addr_o (coord_addr),
    .acc_we_o     (acc_we),
    .acc_addr_o   (acc_addr)
  );

  // coordinate store {z, y, x}
  emng_ram #(.W(96), .D(VERTICES)) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (coord_we),
    .waddr_i (coord_addr),
    .wdata_i ({coord_z_i, coord_y_i, coord_x_i}),
    .raddr_i (coord_addr),
    .rdata_o (coord_rdata)
  );

  // normal accumulators {z, y, x}
  emng_ram #(.W(96), .D(VERTICES)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_addr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_addr),
    .rdata_o (acc_rdata)
  );

  emng_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .coord_rdata_i (coord_rdata),
    .acc_rdata_i   (acc_rdata),
    .acc_wdata_o   (acc_wdata),
    .valid_o       (valid_o),
    .normal_x_o    (normal_x_o),
    .normal_y_o    (normal_y_o),
    .normal_z_o    (normal_z_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule

FILE: hw/rtl/emng_ram.sv
// ----------------------------------------------------------------------------
// emng_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module emng_ram #(
  parameter int W = 32,
  parameter int D = 4096
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/emng_dp.sv
// ----------------------------------------------------------------------------
// emng_dp: arithmetic datapath
// Differences, shared 32x32 multiplier, range fitting, bit-serial square root,
// restoring divider, normal register, accumulator update and result register.
// ----------------------------------------------------------------------------
module emng_dp
  import emng_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  logic [95:0] coord_rdata_i,
  input  logic [95:0] acc_rdata_i,
  output logic [95:0] acc_wdata_o,
  output logic        valid_o,
  output logic [15:0] normal_x_o,
  output logic [15:0] normal_y_o,
  output logic [15:0] normal_z_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  logic signed [31:0] a_q [3];
  logic signed [31:0] b_q [3];
  logic signed [31:0] c_q [3];
  logic signed [32:0] d_q [6];
  logic signed [63:0] v_q [3];
  logic signed [63:0] prod_q;
  logic [63:0]        sum_q;
  logic [63:0]        rad_q;
  logic [34:0]        rem_q;
  logic [31:0]        root_q;
  logic [46:0]        num_q;
  logic [46:0]        den_q;
  logic [14:0]        quo_q;
  logic signed [15:0] n_q [3];
  logic               valid_q;
  logic [15:0]        ox_q, oy_q, oz_q;
  logic [1:0]         ost_q;
  logic               olast_q;

  logic signed [31:0] opa, opb;
  logic [34:0]        rem_t, trial;
  logic [31:0]        av;
  logic [1:0]         j;

  // range status
  always_comb begin
    stat_o.over_d = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (d_q[i][32:30] != 3'b000 && d_q[i][32:30] != 3'b111) stat_o.over_d = 1'b1;
    end
    stat_o.over_v = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!((&v_q[i][63:30]) || !(|v_q[i][63:30]))) stat_o.over_v = 1'b1;
    end
    stat_o.len_zero = (root_q == 32'd0);
  end

  // multiplier operand select: cross terms, then squares
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd_i.mul_sel)
      4'd0:    begin opa = d_q[1][31:0]; opb = d_q[5][31:0]; end
      4'd1:    begin opa = d_q[2][31:0]; opb = d_q[4][31:0]; end
      4'd2:    begin opa = d_q[2][31:0]; opb = d_q[3][31:0]; end
      4'd3:    begin opa = d_q[0][31:0]; opb = d_q[5][31:0]; end
      4'd4:    begin opa = d_q[0][31:0]; opb = d_q[4][31:0]; end
      4'd5:    begin opa = d_q[1][31:0]; opb = d_q[3][31:0]; end
      4'd6:    begin opa = v_q[0][31:0]; opb = v_q[0][31:0]; end
      4'd7:    begin opa = v_q[1][31:0]; opb = v_q[1][31:0]; end
      4'd8:    begin opa = v_q[2][31:0]; opb = v_q[2][31:0]; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // square root step and divider magnitude
  assign rem_t = {rem_q[32:0], rad_q[63:62]};
  assign trial = {1'b0, root_q, 2'b01};
  assign j     = cmd_i.div_sel;
  assign av    = v_q[j][31] ? 32'(-v_q[j][31:0]) : v_q[j][31:0];

  // main datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a) for (int i = 0; i < 3; i++) a_q[i] <= coord_rdata_i[32*i +: 32];
    if (cmd_i.load_b) for (int i = 0; i < 3; i++) b_q[i] <= coord_rdata_i[32*i +: 32];
    if (cmd_i.load_c) for (int i = 0; i < 3; i++) c_q[i] <= coord_rdata_i[32*i +: 32];
    if (cmd_i.diff) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i]   <= {b_q[i][31], b_q[i]} - {a_q[i][31], a_q[i]};
        d_q[i+3] <= {c_q[i][31], c_q[i]} - {b_q[i][31], b_q[i]};
      end
    end
    if (cmd_i.half_d) for (int i = 0; i < 6; i++) d_q[i] <= d_q[i] >>> 1;
    if (cmd_i.mul_en) prod_q <= 64'(opa * opb);
    if (cmd_i.acc_en) begin
      if (cmd_i.acc_sel < 4'd6) begin
        if (cmd_i.acc_sel[0]) v_q[cmd_i.acc_sel[2:1]] <= v_q[cmd_i.acc_sel[2:1]] - prod_q;
        else v_q[cmd_i.acc_sel[2:1]] <= prod_q;
      end else if (cmd_i.acc_sel == 4'd6) begin
        sum_q <= prod_q;
      end else begin
        sum_q <= sum_q + prod_q;
      end
    end
    if (cmd_i.load_acc) begin
      for (int i = 0; i < 3; i++) begin
        v_q[i] <= {{32{acc_rdata_i[32*i+31]}}, acc_rdata_i[32*i +: 32]};
      end
    end
    if (cmd_i.half_v) for (int i = 0; i < 3; i++) v_q[i] <= v_q[i] >>> 1;
    // digit-by-digit square root, two radicand bits a step
    if (cmd_i.sqrt_init) begin
      rad_q  <= sum_q;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[61:0], 2'b00};
      if (rem_t >= trial) begin
        rem_q  <= rem_t - trial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_t;
        root_q <= {root_q[30:0], 1'b0};
      end
    end
    // restoring division, one quotient bit a step
    if (cmd_i.div_init) begin
      num_q <= (47'(av) << 14) + 47'(root_q >> 1);
      den_q <= 47'(root_q) << 14;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      den_q <= den_q >> 1;
      if (num_q >= den_q) begin
        num_q <= num_q - den_q;
        quo_q <= {quo_q[13:0], 1'b1};
      end else begin
        quo_q <= {quo_q[13:0], 1'b0};
      end
    end
    if (cmd_i.div_store) begin
      n_q[j] <= v_q[j][63] ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    end
    if (cmd_i.n_point) begin
      n_q[0] <= '0;
      n_q[1] <= '0;
      n_q[2] <= 16'(ONE_Q14);
    end
    if (cmd_i.n_unit_x) begin
      n_q[0] <= 16'(ONE_Q14);
      n_q[1] <= '0;
      n_q[2] <= '0;
    end
    if (cmd_i.n_zero) for (int i = 0; i < 3; i++) n_q[i] <= '0;
    if (cmd_i.n_neg) for (int i = 0; i < 3; i++) n_q[i] <= -n_q[i];
    // result beat payload
    if (cmd_i.emit) begin
      if (cmd_i.emit_zero || cmd_i.emit_status != ST_OK) begin
        ox_q <= '0;
        oy_q <= '0;
        oz_q <= '0;
      end else begin
        ox_q <= n_q[0];
        oy_q <= n_q[1];
        oz_q <= n_q[2];
      end
      ost_q   <= cmd_i.emit_status;
      olast_q <= cmd_i.emit_last;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  // saturating accumulator update, or zero during a clearing pass
  always_comb begin
    logic signed [32:0] s;
    acc_wdata_o = '0;
    for (int i = 0; i < 3; i++) begin
      s = {acc_rdata_i[32*i+31], acc_rdata_i[32*i +: 32]} + 33'(n_q[i]);
      if (cmd_i.acc_clr) acc_wdata_o[32*i +: 32] = '0;
      else if (s[32] != s[31]) acc_wdata_o[32*i +: 32] = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      else acc_wdata_o[32*i +: 32] = s[31:0];
    end
  end

  assign valid_o    = valid_q;
  assign normal_x_o = ox_q;
  assign normal_y_o = oy_q;
  assign normal_z_o = oz_q;
  assign status_o   = ost_q;
  assign last_o     = olast_q;

endmodule

FILE: hw/rtl/emng_ctrl.sv
// ----------------------------------------------------------------------------
// emng_ctrl: sequencing controller
// Decodes input beats, holds the index group, walks faces and corners and
// drives datapath commands and memory addresses.
// ----------------------------------------------------------------------------
module emng_ctrl
  import emng_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  logic [2:0]     func_i,
  input  logic [11:0]    vertex_i,
  input  cfg_t           cfg_i,
  input  dp_stat_t       stat_i,
  output dp_cmd_t        cmd_o,
  output logic           coord_we_o,
  output logic [VAW-1:0] coord_addr_o,
  output logic           acc_we_o,
  output logic [VAW-1:0] acc_addr_o
);

  typedef enum logic [16:0] {
    S_CLEAR = 17'h00001,
    S_IDLE  = 17'h00002,
    S_FACE  = 17'h00004,
    S_RD    = 17'h00008,
    S_DIFF  = 17'h00010,
    S_FITD  = 17'h00020,
    S_MUL   = 17'h00040,
    S_LDACC = 17'h00080,
    S_FITV  = 17'h00100,
    S_SQ    = 17'h00200,
    S_SQRT  = 17'h00400,
    S_DIV   = 17'h00800,
    S_FIN   = 17'h01000,
    S_POST  = 17'h02000,
    S_ACCRD = 17'h04000,
    S_ACCWR = 17'h08000,
    S_NEXT  = 17'h10000
  } state_e;

  state_e         state_q, state_d;
  logic [5:0]     cnt_q, cnt_d;
  logic [2:0]     face_q, face_d;
  logic [2:0]     corner_q, corner_d;
  logic [1:0]     comp_q, comp_d;
  logic [VAW-1:0] clr_q, clr_d;
  elem_e          kind_q, kind_d;
  logic           rd_q, rd_d;
  logic [3:0]     gcnt_q, gcnt_d;
  logic [11:0]    group_q [GROUP_MAX];
  logic [11:0]    group_d [GROUP_MAX];

  logic [2:0]     nfaces, ncorners;
  logic           size_ok, range_ok, v_ok;

  // element geometry
  always_comb begin
    case (kind_q)
      EL_TET:  begin nfaces = 3'd4; ncorners = 3'd3; end
      EL_HEX:  begin nfaces = 3'd6; ncorners = 3'd4; end
      default: begin nfaces = 3'd1; ncorners = 3'd1; end
    endcase
  end

  // group checks
  always_comb begin
    size_ok  = (gcnt_q == 4'd1) || (gcnt_q == 4'd4) || (gcnt_q == 4'd8);
    range_ok = 1'b1;
    for (int i = 0; i < GROUP_MAX; i++) begin
      if (4'(i) < gcnt_q &&
          !({1'b0, group_q[i]} < cfg_i.vcnt && 32'(group_q[i]) < VERTICES)) range_ok = 1'b0;
    end
    v_ok = {1'b0, vertex_i} < cfg_i.vcnt && 32'(vertex_i) < VERTICES;
  end

  assign busy = (state_q != S_IDLE);

  // memory addresses
  always_comb begin
    coord_addr_o = VAW'(group_q[face_slot(kind_q, face_q, cnt_q[2:0])]);
    acc_addr_o   = VAW'(group_q[face_slot(kind_q, face_q, corner_q)]);
    if (state_q == S_IDLE) begin
      coord_addr_o = VAW'(vertex_i);
      acc_addr_o   = VAW'(vertex_i);
    end else if (state_q == S_CLEAR) begin
      acc_addr_o = clr_q;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    face_d     = face_q;
    corner_d   = corner_q;
    comp_d     = comp_q;
    clr_d      = clr_q;
    kind_d     = kind_q;
    rd_d       = rd_q;
    gcnt_d     = gcnt_q;
    group_d    = group_q;
    cmd_o      = '0;
    coord_we_o = 1'b0;
    acc_we_o   = 1'b0;
    case (state_q)
      S_CLEAR: begin
        acc_we_o      = 1'b1;
        cmd_o.acc_clr = 1'b1;
        clr_d         = clr_q + 1'b1;
        if (clr_q == VAW'(VERTICES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          case (func_e'(func_i))
            FN_WRITE: coord_we_o = (32'(vertex_i) < VERTICES);
            FN_INDEX: begin
              if (gcnt_q < 4'(GROUP_MAX)) begin
                group_d[gcnt_q[2:0]] = vertex_i;
                gcnt_d               = gcnt_q + 4'd1;
              end else begin
                gcnt_d = 4'(GROUP_MAX + 1);
              end
            end
            FN_END: begin
              gcnt_d = '0;
              if (!size_ok || !range_ok) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = size_ok ? ST_RANGE : ST_SIZE;
                cmd_o.emit_last   = 1'b1;
              end else begin
                kind_d  = (gcnt_q == 4'd1) ? EL_POINT : (gcnt_q == 4'd4) ? EL_TET : EL_HEX;
                face_d  = '0;
                rd_d    = 1'b0;
                state_d = S_FACE;
              end
            end
            FN_READ: begin
              if (!v_ok) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = ST_RANGE;
                cmd_o.emit_last   = 1'b1;
              end else begin
                rd_d    = 1'b1;
                state_d = S_LDACC;
              end
            end
            FN_CLEAR: begin
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_FACE: begin
        cnt_d = '0;
        if (kind_q == EL_POINT) begin
          cmd_o.n_point = 1'b1;
          state_d       = S_POST;
        end else begin
          state_d = S_RD;
        end
      end
      // three coordinate reads, data in the cycle after the address
      S_RD: begin
        cmd_o.load_a = (cnt_q == 6'd1);
        cmd_o.load_b = (cnt_q == 6'd2);
        cmd_o.load_c = (cnt_q == 6'd3);
        cnt_d        = cnt_q + 6'd1;
        if (cnt_q == 6'd3) state_d = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = S_FITD;
      end
      S_FITD: begin
        cnt_d = '0;
        if (stat_i.over_d) cmd_o.half_d = 1'b1;
        else state_d = S_MUL;
      end
      // six products, each subtracted or stored the cycle after
      S_MUL: begin
        cmd_o.mul_en  = (cnt_q < 6'd6);
        cmd_o.mul_sel = cnt_q[3:0];
        cmd_o.acc_en  = (cnt_q != 6'd0);
        cmd_o.acc_sel = 4'(cnt_q - 6'd1);
        cnt_d         = cnt_q + 6'd1;
        if (cnt_q == 6'd6) state_d = S_FITV;
      end
      S_LDACC: begin
        cmd_o.load_acc = 1'b1;
        state_d        = S_FITV;
      end
      S_FITV: begin
        cnt_d = '0;
        if (stat_i.over_v) cmd_o.half_v = 1'b1;
        else state_d = S_SQ;
      end
      S_SQ: begin
        cmd_o.mul_en  = (cnt_q < 6'd3);
        cmd_o.mul_sel = 4'(cnt_q + 6'd6);
        cmd_o.acc_en  = (cnt_q != 6'd0);
        cmd_o.acc_sel = 4'(cnt_q + 6'd5);
        cnt_d         = cnt_q + 6'd1;
        if (cnt_q == 6'd3) begin
          cnt_d   = '0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_init = (cnt_q == 6'd0);
        cmd_o.sqrt_step = (cnt_q != 6'd0);
        cnt_d           = cnt_q + 6'd1;
        if (cnt_q == 6'd32) begin
          cnt_d   = '0;
          comp_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_sel = comp_q;
        if (stat_i.len_zero) begin
          cmd_o.n_zero   = rd_q;
          cmd_o.n_unit_x = !rd_q;
          state_d        = S_FIN;
        end else begin
          cmd_o.div_init  = (cnt_q == 6'd0);
          cmd_o.div_step  = (cnt_q != 6'd0) && (cnt_q != 6'd16);
          cmd_o.div_store = (cnt_q == 6'd16);
          cnt_d           = cnt_q + 6'd1;
          if (cnt_q == 6'd16) begin
            cnt_d  = '0;
            comp_d = comp_q + 2'd1;
            if (comp_q == 2'd2) state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (rd_q) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_OK;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end else begin
          cmd_o.n_neg = !cfg_i.ccw;
          state_d     = S_POST;
        end
      end
      S_POST: begin
        corner_d = '0;
        if (cfg_i.pvm) begin
          state_d = S_ACCRD;
        end else begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_OK;
          cmd_o.emit_last   = (face_q == nfaces - 3'd1);
          state_d           = S_NEXT;
        end
      end
      S_ACCRD: state_d = S_ACCWR;
      S_ACCWR: begin
        acc_we_o = 1'b1;
        corner_d = corner_q + 3'd1;
        state_d  = (corner_q == ncorners - 3'd1) ? S_NEXT : S_ACCRD;
      end
      S_NEXT: begin
        if (face_q == nfaces - 3'd1) begin
          cmd_o.emit        = cfg_i.pvm;
          cmd_o.emit_zero   = 1'b1;
          cmd_o.emit_status = ST_OK;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end else begin
          face_d  = face_q + 3'd1;
          state_d = S_FACE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      face_q  <= '0;
      corner_q <= '0;
      comp_q  <= '0;
      clr_q   <= '0;
      kind_q  <= EL_POINT;
      rd_q    <= 1'b0;
      gcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      face_q  <= face_d;
      corner_q <= corner_d;
      comp_q  <= comp_d;
      clr_q   <= clr_d;
      kind_q  <= kind_d;
      rd_q    <= rd_d;
      gcnt_q  <= gcnt_d;
    end
  end

  // index group, no reset
  always_ff @(posedge clk_i) begin
    group_q <= group_d;
  end

endmodule
